// ----- design/psm_pkg.sv -----
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types, constants and rounding helper for the planar shadow matrix.
// ----------------------------------------------------------------------------
package psm_pkg;

    localparam int COEF_BITS  = 30;
    localparam int NORM_BITS  = 31;
    localparam int OUT_W      = 48;

    localparam int SQ_STEPS   = 4;
    localparam int SQ_STAGES  = 8;
    localparam int DV_BITS    = 31;
    localparam int DV_STEPS   = 4;
    localparam int DV_STAGES  = 8;

    localparam int GRP_N      = 9;

    typedef enum logic [1:0] {
        LIGHT_X = 2'd0,
        LIGHT_Y = 2'd1,
        LIGHT_Z = 2'd2,
        LIGHT_W = 2'd3
    } light_idx_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } sqrt_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [30:0] q;
    } div_lane_t;

    typedef struct packed {
        logic [31:0]          len;
        div_lane_t [2:0]      lane;
    } div_t;

    // round half away from zero, then shift right by sh (sh >= 1)
    function automatic logic signed [66:0] rnd_half_away(input logic signed [66:0] v,
                                                         input int unsigned sh);
        logic [66:0] m;
        logic [66:0] r;
        m = v[66] ? 67'(-v) : 67'(v);
        r = (m + (67'd1 << (sh - 1))) >> sh;
        return v[66] ? -$signed(r) : $signed(r);
    endfunction

endpackage

// ----- design/planar_shadow_matrix_unit.sv -----
// ----------------------------------------------------------------------------
// planar_shadow_matrix_unit
// A request passes the front stages, the row serializer and row stages M, R and O;
// rows leave one a cycle unless m_ready stalls them. The row serializer drives one
// 4-entry matrix row per cycle through a 4-multiplier stage, taking the next request as the last row issues.
// Reset clears all valid bits and loads the light registers; no clearing pass.
// Front end: cross product, normalize, 8-stage sqrt, 8-stage divide, D/temp.
// ----------------------------------------------------------------------------
module planar_shadow_matrix_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_wr_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_p0_x,
    input  logic signed [31:0]  s_p0_y,
    input  logic signed [31:0]  s_p0_z,
    input  logic signed [31:0]  s_p1_x,
    input  logic signed [31:0]  s_p1_y,
    input  logic signed [31:0]  s_p1_z,
    input  logic signed [31:0]  s_p2_x,
    input  logic signed [31:0]  s_p2_y,
    input  logic signed [31:0]  s_p2_z,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_row_index,
    output logic signed [47:0]  m_val_c0,
    output logic signed [47:0]  m_val_c1,
    output logic signed [47:0]  m_val_c2,
    output logic signed [47:0]  m_val_c3,
    output logic                m_degenerate,
    output logic                m_last_row
);

    localparam int TM     = 64 - FRAC_BITS;
    localparam int TERM_W = TM + 1;
    localparam int TW     = TM + 2;
    localparam int EW     = TM + 3;
    localparam int SW     = (EW > 49) ? EW : 49;

    localparam logic signed [SW-1:0] SAT_MAX = {{(SW-47){1'b0}}, {47{1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = {{(SW-47){1'b1}}, {47{1'b0}}};

    // front stage indexes
    localparam int S_V   = 0;
    localparam int S_MUL = 1;
    localparam int S_CR  = 2;
    localparam int S_MAG = 3;
    localparam int S_GRP = 4;
    localparam int S_BL  = 5;
    localparam int S_NRM = 6;
    localparam int S_SQR = 7;
    localparam int S_SUM = 8;
    localparam int S_DS  = S_SUM + psm_pkg::SQ_STAGES + 1;
    localparam int S_CF  = S_DS + psm_pkg::DV_STAGES + 1;
    localparam int S_PR  = S_CF + 1;
    localparam int S_AD  = S_CF + 2;
    localparam int S_RD  = S_CF + 3;
    localparam int S_MW  = S_CF + 4;
    localparam int S_RW  = S_CF + 5;
    localparam int S_TP  = S_CF + 6;
    localparam int NF    = S_TP + 1;

    localparam logic [1:0] ROW_LAST = 2'd3;

    // light registers
    logic signed [31:0] light_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_reg[psm_pkg::LIGHT_X] <= 32'sd3932160;
            light_reg[psm_pkg::LIGHT_Y] <= 32'sd13107200;
            light_reg[psm_pkg::LIGHT_Z] <= -32'sd3276800;
            light_reg[psm_pkg::LIGHT_W] <= 32'sd65536;
        end else if (cfg_wr_en) begin
            light_reg[cfg_index] <= cfg_wr_data;
        end
    end

    // front pipeline control
    logic [NF-1:0] vld_reg;
    logic          adv;
    logic          it_take;

    assign adv     = !vld_reg[NF-1] || it_take;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NF-2:0], s_valid};
        end
    end

    // carried fields
    logic signed [31:0] p2_reg    [S_V:S_CF][3];
    logic [2:0]         neg_reg   [S_MAG:S_CF-1];
    logic               degen_reg [S_BL:S_TP];
    logic [30:0]        n_reg     [S_NRM:S_DS-1][3];
    logic [65:0]        mag_reg   [S_MAG:S_BL][3];
    logic signed [31:0] coef_reg  [S_CF:S_TP][3];
    logic signed [34:0] dotr_reg  [S_RD:S_RW];
    logic signed [34:0] dcoef_reg [S_RD:S_TP];

    // stage V
    logic signed [32:0] v1_reg [3], v1_next [3];
    logic signed [32:0] v2_reg [3], v2_next [3];

    always_comb begin
        v1_next[0] = 33'(s_p0_x) - 33'(s_p1_x);
        v1_next[1] = 33'(s_p0_y) - 33'(s_p1_y);
        v1_next[2] = 33'(s_p0_z) - 33'(s_p1_z);
        v2_next[0] = 33'(s_p1_x) - 33'(s_p2_x);
        v2_next[1] = 33'(s_p1_y) - 33'(s_p2_y);
        v2_next[2] = 33'(s_p1_z) - 33'(s_p2_z);
    end

    // stage MUL
    logic signed [65:0] pr_reg [6], pr_next [6];

    always_comb begin
        pr_next[0] = v1_reg[1] * v2_reg[2];
        pr_next[1] = v1_reg[2] * v2_reg[1];
        pr_next[2] = v1_reg[2] * v2_reg[0];
        pr_next[3] = v1_reg[0] * v2_reg[2];
        pr_next[4] = v1_reg[0] * v2_reg[1];
        pr_next[5] = v1_reg[1] * v2_reg[0];
    end

    // stage CR
    logic signed [66:0] cr_reg [3], cr_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cr_next[i] = 67'(pr_reg[2*i]) - 67'(pr_reg[2*i+1]);
        end
    end

    // stage MAG
    logic [65:0] mag_next [3];
    logic [2:0]  neg_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg_next[i] = cr_reg[i][66];
            mag_next[i] = cr_reg[i][66] ? 66'(-cr_reg[i]) : 66'(cr_reg[i]);
        end
    end

    // stage GRP: per-byte leading one
    logic [psm_pkg::GRP_N-1:0] gnz_reg, gnz_next;
    logic [2:0]                gpos_reg [psm_pkg::GRP_N], gpos_next [psm_pkg::GRP_N];

    always_comb begin
        logic [8*psm_pkg::GRP_N-1:0] w;
        w = (8*psm_pkg::GRP_N)'(mag_reg[S_MAG][0] | mag_reg[S_MAG][1] | mag_reg[S_MAG][2]);
        for (int g = 0; g < psm_pkg::GRP_N; g++) begin
            gnz_next[g]  = |w[g*8 +: 8];
            gpos_next[g] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (w[g*8+b]) begin
                    gpos_next[g] = 3'(b);
                end
            end
        end
    end

    // stage BL: bit length
    logic [6:0] blen_reg, blen_next;
    logic       degen_next;

    always_comb begin
        blen_next = 7'd0;
        for (int g = 0; g < psm_pkg::GRP_N; g++) begin
            if (gnz_reg[g]) begin
                blen_next = 7'(g*8) + 7'(gpos_reg[g]) + 7'd1;
            end
        end
        degen_next = ~|gnz_reg;
    end

    // stage NRM: scale so the largest component has 31 bits
    logic [30:0] n_next [3];

    always_comb begin
        logic [96:0] sh;
        for (int i = 0; i < 3; i++) begin
            sh = {mag_reg[S_BL][i], 31'b0} >> blen_reg;
            n_next[i] = sh[30:0];
        end
    end

    // stage SQR
    logic [61:0] sqr_reg [3], sqr_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sqr_next[i] = 62'(n_reg[S_NRM][i]) * 62'(n_reg[S_NRM][i]);
        end
    end

    // stage SUM feeds the root pipeline
    psm_pkg::sqrt_t rt_reg  [0:psm_pkg::SQ_STAGES];
    psm_pkg::sqrt_t rt_next [0:psm_pkg::SQ_STAGES];

    always_comb begin
        rt_next[0].rem  = '0;
        rt_next[0].root = '0;
        rt_next[0].rad  = 64'(sqr_reg[0]) + 64'(sqr_reg[1]) + 64'(sqr_reg[2]);
    end

    for (genvar k = 0; k < psm_pkg::SQ_STAGES; k++) begin : g_sqrt
        always_comb begin
            psm_pkg::sqrt_t st;
            logic [33:0]    t;
            logic [33:0]    trial;
            st = rt_reg[k];
            for (int j = 0; j < psm_pkg::SQ_STEPS; j++) begin
                t     = {st.rem[31:0], st.rad[63:62]};
                trial = {st.root, 2'b01};
                if (t >= trial) begin
                    st.rem  = t - trial;
                    st.root = {st.root[30:0], 1'b1};
                end else begin
                    st.rem  = t;
                    st.root = {st.root[30:0], 1'b0};
                end
                st.rad = {st.rad[61:0], 2'b00};
            end
            rt_next[k+1] = st;
        end
    end

    // stage DS feeds the divide pipeline
    psm_pkg::div_t dv_reg  [0:psm_pkg::DV_STAGES];
    psm_pkg::div_t dv_next [0:psm_pkg::DV_STAGES];

    always_comb begin
        logic [61:0] num;
        dv_next[0].len = rt_reg[psm_pkg::SQ_STAGES].root;
        for (int i = 0; i < 3; i++) begin
            num = 62'({n_reg[S_DS-1][i], 30'b0})
                + 62'(rt_reg[psm_pkg::SQ_STAGES].root[31:1]);
            dv_next[0].lane[i].rem = {1'b0, num[61:31]};
            dv_next[0].lane[i].q   = num[30:0];
        end
    end

    for (genvar k = 0; k < psm_pkg::DV_STAGES; k++) begin : g_div
        always_comb begin
            psm_pkg::div_t st;
            logic [32:0]   t;
            st = dv_reg[k];
            for (int j = 0; j < psm_pkg::DV_STEPS; j++) begin
                if (k*psm_pkg::DV_STEPS + j < psm_pkg::DV_BITS) begin
                    for (int l = 0; l < 3; l++) begin
                        t = {st.lane[l].rem, st.lane[l].q[30]};
                        if (t >= {1'b0, st.len}) begin
                            st.lane[l].rem = 32'(t - {1'b0, st.len});
                            st.lane[l].q   = {st.lane[l].q[29:0], 1'b1};
                        end else begin
                            st.lane[l].rem = t[31:0];
                            st.lane[l].q   = {st.lane[l].q[29:0], 1'b0};
                        end
                    end
                end
            end
            dv_next[k+1] = st;
        end
    end

    // stage CF
    logic signed [31:0] coef_next [3];

    always_comb begin
        logic signed [31:0] m;
        for (int i = 0; i < 3; i++) begin
            m = $signed({1'b0, dv_reg[psm_pkg::DV_STAGES].lane[i].q});
            if (degen_reg[S_CF-1]) begin
                coef_next[i] = '0;
            end else begin
                coef_next[i] = neg_reg[S_CF-1][i] ? -m : m;
            end
        end
    end

    // stage PR
    logic signed [63:0] pa_reg [3], pa_next [3];
    logic signed [63:0] pd_reg [3], pd_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pa_next[i] = coef_reg[S_CF][i] * p2_reg[S_CF][i];
            pd_next[i] = coef_reg[S_CF][i] * light_reg[i];
        end
    end

    // stage AD
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] dot_reg, dot_next;

    always_comb begin
        acc_next = pa_reg[0] + pa_reg[1] + pa_reg[2];
        dot_next = pd_reg[0] + pd_reg[1] + pd_reg[2];
    end

    // stage RD
    logic signed [34:0] dcoef_next, dotr_next;

    always_comb begin
        dcoef_next = 35'(-psm_pkg::rnd_half_away(67'(acc_reg), psm_pkg::COEF_BITS));
        dotr_next  = 35'(psm_pkg::rnd_half_away(67'(dot_reg), psm_pkg::COEF_BITS));
    end

    // stage MW
    logic signed [66:0] pw_reg, pw_next;

    assign pw_next = dcoef_reg[S_RD] * light_reg[psm_pkg::LIGHT_W];

    // stage RW
    logic signed [TW-1:0] tw_reg, tw_next;

    assign tw_next = TW'(psm_pkg::rnd_half_away(pw_reg, FRAC_BITS));

    // stage TP
    logic signed [TW-1:0] temp_reg, temp_next;

    assign temp_next = TW'(dotr_reg[S_RW]) + tw_reg;

    // front registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            pr_reg <= pr_next;
            cr_reg <= cr_next;
            gnz_reg <= gnz_next;
            gpos_reg <= gpos_next;
            blen_reg <= blen_next;
            sqr_reg <= sqr_next;
            for (int k = 0; k <= psm_pkg::SQ_STAGES; k++) begin
                rt_reg[k] <= rt_next[k];
            end
            for (int k = 0; k <= psm_pkg::DV_STAGES; k++) begin
                dv_reg[k] <= dv_next[k];
            end
            pa_reg <= pa_next;
            pd_reg <= pd_next;
            acc_reg <= acc_next;
            dot_reg <= dot_next;
            pw_reg <= pw_next;
            tw_reg <= tw_next;
            temp_reg <= temp_next;

            p2_reg[S_V][0] <= s_p2_x;
            p2_reg[S_V][1] <= s_p2_y;
            p2_reg[S_V][2] <= s_p2_z;
            for (int k = S_V + 1; k <= S_CF; k++) begin
                p2_reg[k] <= p2_reg[k-1];
            end
            neg_reg[S_MAG] <= neg_next;
            for (int k = S_MAG + 1; k <= S_CF - 1; k++) begin
                neg_reg[k] <= neg_reg[k-1];
            end
            mag_reg[S_MAG] <= mag_next;
            for (int k = S_MAG + 1; k <= S_BL; k++) begin
                mag_reg[k] <= mag_reg[k-1];
            end
            degen_reg[S_BL] <= degen_next;
            for (int k = S_BL + 1; k <= S_TP; k++) begin
                degen_reg[k] <= degen_reg[k-1];
            end
            n_reg[S_NRM] <= n_next;
            for (int k = S_NRM + 1; k <= S_DS - 1; k++) begin
                n_reg[k] <= n_reg[k-1];
            end
            coef_reg[S_CF] <= coef_next;
            for (int k = S_CF + 1; k <= S_TP; k++) begin
                coef_reg[k] <= coef_reg[k-1];
            end
            dotr_reg[S_RD] <= dotr_next;
            for (int k = S_RD + 1; k <= S_RW; k++) begin
                dotr_reg[k] <= dotr_reg[k-1];
            end
            dcoef_reg[S_RD] <= dcoef_next;
            for (int k = S_RD + 1; k <= S_TP; k++) begin
                dcoef_reg[k] <= dcoef_reg[k-1];
            end
        end
    end

    // row serializer
    logic                 it_vld_reg;
    logic [1:0]           it_cnt_reg;
    logic signed [34:0]   it_coef_reg [4];
    logic signed [TW-1:0] it_temp_reg;
    logic                 it_degen_reg;
    logic                 emit;
    logic                 en_m, en_r, en_o;

    assign it_take = !it_vld_reg || (it_cnt_reg == ROW_LAST && en_m);
    assign emit    = it_vld_reg && en_m;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            it_vld_reg <= 1'b0;
            it_cnt_reg <= 2'd0;
        end else begin
            if (emit) begin
                it_cnt_reg <= it_cnt_reg + 2'd1;
            end
            if (it_take) begin
                it_vld_reg <= vld_reg[NF-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (it_take) begin
            for (int i = 0; i < 3; i++) begin
                it_coef_reg[i] <= 35'(coef_reg[S_TP][i]);
            end
            it_coef_reg[3] <= dcoef_reg[S_TP];
            it_temp_reg    <= temp_reg;
            it_degen_reg   <= degen_reg[S_TP];
        end
    end

    // row stage M: products
    logic                 mv_reg;
    logic [1:0]           m_row_reg;
    logic signed [TW-1:0] m_temp_reg;
    logic                 m_degen_reg;
    logic signed [66:0]   m_prod_reg [4], m_prod_next [4];

    assign en_m = !mv_reg || en_r;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            m_prod_next[c] = light_reg[c] * it_coef_reg[it_cnt_reg];
        end
    end

    // row stage R: rounded terms
    logic                   rv_reg;
    logic [1:0]             r_row_reg;
    logic signed [TW-1:0]   r_temp_reg;
    logic                   r_degen_reg;
    logic signed [TERM_W-1:0] r_term_reg [4], r_term_next [4];

    assign en_r = !rv_reg || en_o;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (m_row_reg == ROW_LAST) begin
                r_term_next[c] = TERM_W'(psm_pkg::rnd_half_away(m_prod_reg[c], FRAC_BITS));
            end else begin
                r_term_next[c] = TERM_W'(psm_pkg::rnd_half_away(m_prod_reg[c],
                                                                 psm_pkg::COEF_BITS));
            end
        end
    end

    // row stage O: subtract and saturate
    logic                     ov_reg;
    logic [1:0]               o_row_reg;
    logic                     o_degen_reg;
    logic                     o_last_reg;
    logic signed [47:0]       o_val_reg [4], o_val_next [4];

    assign en_o = !ov_reg || m_ready;

    always_comb begin
        logic signed [EW-1:0] v;
        logic signed [SW-1:0] vx;
        for (int c = 0; c < 4; c++) begin
            v = ((r_row_reg == 2'(c)) ? EW'(r_temp_reg) : EW'(0)) - EW'(r_term_reg[c]);
            vx = SW'(v);
            if (vx > SAT_MAX) begin
                o_val_next[c] = SAT_MAX[47:0];
            end else if (vx < SAT_MIN) begin
                o_val_next[c] = SAT_MIN[47:0];
            end else begin
                o_val_next[c] = vx[47:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
            rv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            if (en_m) begin
                mv_reg <= it_vld_reg;
            end
            if (en_r) begin
                rv_reg <= mv_reg;
            end
            if (en_o) begin
                ov_reg <= rv_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_m) begin
            m_row_reg   <= it_cnt_reg;
            m_temp_reg  <= it_temp_reg;
            m_degen_reg <= it_degen_reg;
            m_prod_reg  <= m_prod_next;
        end
        if (en_r) begin
            r_row_reg   <= m_row_reg;
            r_temp_reg  <= m_temp_reg;
            r_degen_reg <= m_degen_reg;
            r_term_reg  <= r_term_next;
        end
        if (en_o) begin
            o_row_reg   <= r_row_reg;
            o_degen_reg <= r_degen_reg;
            o_last_reg  <= (r_row_reg == ROW_LAST);
            o_val_reg   <= o_val_next;
        end
    end

    assign m_valid      = ov_reg;
    assign m_row_index  = o_row_reg;
    assign m_val_c0     = o_val_reg[0];
    assign m_val_c1     = o_val_reg[1];
    assign m_val_c2     = o_val_reg[2];
    assign m_val_c3     = o_val_reg[3];
    assign m_degenerate = o_degen_reg;
    assign m_last_row   = o_last_reg;

`ifndef NO_ASSERTIONS
    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !it_vld_reg |-> it_cnt_reg == 2'd0)
        else $error("row counter not at zero while serializer empty");

    a_emit_row: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> mv_reg && m_row_reg == $past(it_cnt_reg))
        else $error("issued row lost or misnumbered");

    a_row_order_mr: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && rv_reg |-> m_row_reg == r_row_reg + 2'd1)
        else $error("rows out of order between product and round stages");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg && o_degen_reg |-> (o_val_reg[0] == 48'sd0 && o_val_reg[1] == 48'sd0 &&
                                   o_val_reg[2] == 48'sd0 && o_val_reg[3] == 48'sd0))
        else $error("degenerate request produced nonzero entries");
`endif

endmodule
